// ----- rtl/core/fdss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdss_pkg
// Types, constants and decode functions for the four-digit display scanner.
// ----------------------------------------------------------------------------
package fdss_pkg;

    localparam int NUM_DIGITS   = 4;
    localparam int NUMBER_W     = 32;
    localparam int PLACE_W      = 3;
    localparam int CODE_W       = 4;
    localparam int VALUE_W      = 14;
    localparam int QUO_W        = 10;
    localparam int Q100_W       = 7;
    localparam int SEG_W        = 8;
    localparam int SCAN_W       = 2;
    localparam int POINT_BIT    = 7;
    localparam int S_DATA_W     = 40;
    localparam int M_DATA_W     = 16;

    localparam logic [NUMBER_W-1:0] MAX_SHOWN      = 32'd9999;
    localparam logic [CODE_W-1:0]   BLANK_CODE     = 4'd10;
    localparam logic [PLACE_W-1:0]  NO_POINT       = 3'b111;
    localparam logic [12:0]         RECIP_TEN      = 13'd6554;
    localparam logic [12:0]         RECIP_HUNDRED  = 13'd5243;
    localparam logic [14:0]         RECIP_THOUSAND = 15'd16778;
    localparam logic [SEG_W-1:0]    SEG_BLANK      = 8'hFF;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_CLEAR   = 2'd1,
        KIND_REFRESH = 2'd2
    } kind_t;

    typedef struct packed {
        logic [QUO_W-1:0]  quo;
        logic [CODE_W-1:0] rem;
    } divmod_t;

    // Valid for values up to 9999; the reciprocal error stays under one tenth.
    function automatic divmod_t div10(input logic [VALUE_W-1:0] v);
        logic [26:0]        prod;
        logic [QUO_W-1:0]   q;
        logic [VALUE_W-1:0] back;
        divmod_t            res;
        prod    = 27'(v) * 27'(RECIP_TEN);
        q       = prod[25:16];
        back    = VALUE_W'(q) * VALUE_W'(10);
        res.quo = q;
        res.rem = CODE_W'(v - back);
        return res;
    endfunction

    // Valid for values up to 9999.
    function automatic logic [Q100_W-1:0] div100(input logic [VALUE_W-1:0] v);
        logic [26:0] prod;
        prod = 27'(v) * 27'(RECIP_HUNDRED);
        return prod[25:19];
    endfunction

    // Valid for values up to 9999.
    function automatic logic [CODE_W-1:0] div1000(input logic [VALUE_W-1:0] v);
        logic [28:0] prod;
        prod = 29'(v) * 29'(RECIP_THOUSAND);
        return prod[27:24];
    endfunction

    function automatic logic [SEG_W-1:0] seg_decode(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] seg;
        case (code)
            4'd0: seg = 8'hC0;
            4'd1: seg = 8'hF9;
            4'd2: seg = 8'hA4;
            4'd3: seg = 8'hB0;
            4'd4: seg = 8'h99;
            4'd5: seg = 8'h92;
            4'd6: seg = 8'h82;
            4'd7: seg = 8'hF8;
            4'd8: seg = 8'h80;
            4'd9: seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ----- rtl/core/four_digit_seven_segment_scanner_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scanner_core
// Multiplexed four-digit display driver: load, clear and refresh items.
// ----------------------------------------------------------------------------
// Path: a refresh item is held in the input register, and its result is then
// registered in the output register, where m_tvalid rises.
// Throughput: one item per cycle while m_tready is high. A refresh item waits
// in the input register while a result is held, which stalls the input.
// Reset: all digits blank, no point, scan at the leftmost digit, both
// registers empty.
module four_digit_seven_segment_scanner_core
    import fdss_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // number [31:0], dot_position [34:32]
    input  logic [1:0]          s_tuser,   // kind [1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // segments [7:0], digit_enables [11:8],
                                           // scan_digit [13:12]
);

    logic                in_valid_reg;
    logic [1:0]          in_kind_reg;
    logic [NUMBER_W-1:0] in_number_reg;
    logic [PLACE_W-1:0]  in_place_reg;

    logic [CODE_W-1:0]   codes_reg [NUM_DIGITS];
    logic [CODE_W-1:0]   codes_next [NUM_DIGITS];
    logic [PLACE_W-1:0]  point_reg;
    logic [PLACE_W-1:0]  point_next;
    logic [SCAN_W-1:0]   scan_reg;
    logic [SCAN_W-1:0]   scan_next;

    logic                out_valid_reg;
    logic [SEG_W-1:0]    out_seg_reg;
    logic [NUM_DIGITS-1:0] out_enables_reg;
    logic [SCAN_W-1:0]   out_scan_reg;

    logic                is_refresh;
    logic                out_free;
    logic                advance;
    logic                out_load;
    logic                in_range;
    logic [VALUE_W-1:0]  value;
    divmod_t             dm0;
    logic [Q100_W-1:0]   q100;
    logic [CODE_W-1:0]   q1000;
    logic [CODE_W-1:0]   digit1;
    logic [CODE_W-1:0]   digit2;
    logic [SEG_W-1:0]    seg;
    logic                point_hit;

    assign is_refresh = (in_kind_reg == KIND_REFRESH);
    assign out_free   = !out_valid_reg || m_tready;
    assign advance    = in_valid_reg && (!is_refresh || out_free);
    assign out_load   = advance && is_refresh;
    assign s_tready   = !in_valid_reg || advance;

    assign in_range = !in_number_reg[NUMBER_W-1] && (in_number_reg <= MAX_SHOWN);
    assign value    = in_number_reg[VALUE_W-1:0];

    always_comb begin
        dm0    = div10(value);
        q100   = div100(value);
        q1000  = div1000(value);
        digit1 = CODE_W'(dm0.quo - QUO_W'(q100) * QUO_W'(10));
        digit2 = CODE_W'(q100 - Q100_W'(q1000) * Q100_W'(10));
    end

    always_comb begin
        codes_next = codes_reg;
        point_next = point_reg;
        scan_next  = scan_reg;
        if (advance) begin
            case (in_kind_reg)
                KIND_LOAD: begin
                    if (in_range) begin
                        codes_next[3] = dm0.rem;
                        codes_next[2] = (dm0.quo != '0) ? digit1 : BLANK_CODE;
                        codes_next[1] = (q100 != '0) ? digit2 : BLANK_CODE;
                        codes_next[0] = (q1000 != '0) ? q1000 : BLANK_CODE;
                        point_next    = in_place_reg;
                    end else begin
                        for (int i = 0; i < NUM_DIGITS; i++) begin
                            codes_next[i] = BLANK_CODE;
                        end
                        point_next = NO_POINT;
                    end
                end
                KIND_CLEAR: begin
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        codes_next[i] = BLANK_CODE;
                    end
                    point_next = NO_POINT;
                end
                KIND_REFRESH: begin
                    scan_next = scan_reg + SCAN_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        point_hit = !point_reg[PLACE_W-1] &&
                    (scan_reg == SCAN_W'(2'd3 - point_reg[SCAN_W-1:0]));
        seg = seg_decode(codes_reg[scan_reg]);
        if (point_hit) begin
            seg[POINT_BIT] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            point_reg     <= NO_POINT;
            scan_reg      <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                codes_reg[i] <= BLANK_CODE;
            end
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            codes_reg <= codes_next;
            point_reg <= point_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg   <= s_tuser;
            in_number_reg <= s_tdata[NUMBER_W-1:0];
            in_place_reg  <= s_tdata[NUMBER_W+PLACE_W-1:NUMBER_W];
        end
        if (out_load) begin
            out_seg_reg     <= seg;
            out_enables_reg <= ~(NUM_DIGITS'(1) << scan_reg);
            out_scan_reg    <= scan_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_scan_reg, out_enables_reg, out_seg_reg};

    a_one_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($countones(out_enables_reg) == NUM_DIGITS - 1))
        else $error("more or less than one digit enabled");

    a_scan_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !out_enables_reg[out_scan_reg])
        else $error("enabled digit does not match scan index");

    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (scan_reg == $past(scan_reg) + SCAN_W'(1)))
        else $error("scan index did not advance on refresh");

    a_clear_blanks: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_kind_reg == KIND_CLEAR) |=>
        (point_reg == NO_POINT && codes_reg[0] == BLANK_CODE &&
         codes_reg[3] == BLANK_CODE))
        else $error("clear did not blank the display");

endmodule
